// File: rtl/rgbhsv_pkg.sv
`default_nettype none

package rgbhsv_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int CH_W = CHANNEL_BITS;
  localparam int HUE_W = 13;

  // hue quotient is at most HUE_SECTOR, so it needs 10 bits
  localparam int HQ_W = 10;
  // divider quotient width covers both saturation and hue
  localparam int QW = (CH_W > HQ_W) ? CH_W : HQ_W;
  localparam int NUM_W = CH_W + QW;

  localparam logic [HUE_W-1:0] HUE_SECTOR = HUE_W'(960);
  localparam logic [HUE_W-1:0] HUE_GREEN = HUE_W'(1920);
  localparam logic [HUE_W-1:0] HUE_BLUE = HUE_W'(3840);
  localparam logic [HUE_W-1:0] HUE_FULL = HUE_W'(5760);

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // one word in flight through the divider stages
  typedef struct packed {
    logic            grey;
    logic            neg;
    sector_t         sector;
    logic [CH_W-1:0] mx;
    logic [CH_W-1:0] delta;
    logic [CH_W-1:0] sat_rem;
    logic [QW-1:0]   sat_lo;
    logic [CH_W-1:0] hue_rem;
    logic [QW-1:0]   hue_lo;
  } pix_t;

endpackage

`default_nettype wire

// File: rtl/rgbhsv_div_stage.sv
`default_nettype none

// One restoring step for both quotients: shift in one numerator bit,
// subtract the divisor where it fits, shift the quotient bit in.
module rgbhsv_div_stage import rgbhsv_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic advance,
  input  wire logic in_valid,
  input  wire pix_t in_data,
  output logic      out_valid,
  output pix_t      out_data
);

  logic [CH_W:0] sat_t;
  logic [CH_W:0] hue_t;
  logic          sat_q;
  logic          hue_q;
  pix_t          data_next;

  always_comb begin
    sat_t = {in_data.sat_rem, in_data.sat_lo[QW-1]};
    hue_t = {in_data.hue_rem, in_data.hue_lo[QW-1]};
    sat_q = (sat_t >= {1'b0, in_data.mx});
    hue_q = (hue_t >= {1'b0, in_data.delta});

    data_next = in_data;
    data_next.sat_rem = sat_q ? CH_W'(sat_t - {1'b0, in_data.mx}) : sat_t[CH_W-1:0];
    data_next.hue_rem = hue_q ? CH_W'(hue_t - {1'b0, in_data.delta}) : hue_t[CH_W-1:0];
    data_next.sat_lo = {in_data.sat_lo[QW-2:0], sat_q};
    data_next.hue_lo = {in_data.hue_lo[QW-2:0], hue_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rgb_to_hsv_converter.sv
// RGB to HSV converter, one pixel per clock while the output is not held.
// Input channel: red, green, blue with in_valid / in_ready. Output channel:
// hue (1/16 degree, 0..5759), saturation and brightness with out_valid /
// out_ready. A word moves when valid and ready are both high.
// Brightness is the largest channel, saturation floor(255*delta/max), hue
// the six-sector rule; a grey pixel gives hue and saturation of 0.
// From input to output register the word passes a stage for max/min/sector,
// a stage for the numerators, ten divider stages (one quotient bit each for
// both divisions, set by the 10-bit hue quotient) and a stage for the hue
// offset. A new word is taken every cycle unless out_ready holds the output.
// The whole pipeline advances together: when the output word is held by
// out_ready low, in_ready drops and every stage keeps its word.
// Reset clears all valid bits; nothing else is kept between words.
`default_nettype none

module rgb_to_hsv_converter import rgbhsv_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [CH_W-1:0]  red,
  input  wire logic [CH_W-1:0]  green,
  input  wire logic [CH_W-1:0]  blue,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [HUE_W-1:0]      hue,
  output logic [CH_W-1:0]       saturation,
  output logic [CH_W-1:0]       brightness
);

  logic advance;

  assign advance  = ~out_valid | out_ready;
  assign in_ready = advance;

  // stage A: max, min, sector
  logic [CH_W-1:0] mx_rg;
  logic [CH_W-1:0] mn_rg;
  logic [CH_W-1:0] mx_next;
  logic [CH_W-1:0] mn_next;
  logic [CH_W-1:0] n_next;
  logic            neg_next;
  sector_t         sector_next;

  logic            a_valid;
  logic            a_grey;
  logic            a_neg;
  sector_t         a_sector;
  logic [CH_W-1:0] a_mx;
  logic [CH_W-1:0] a_delta;
  logic [CH_W-1:0] a_n;

  always_comb begin
    mx_rg   = (red > green) ? red : green;
    mn_rg   = (red < green) ? red : green;
    mx_next = (mx_rg > blue) ? mx_rg : blue;
    mn_next = (mn_rg < blue) ? mn_rg : blue;
    if (red >= mx_next) begin
      sector_next = SEC_RED;
      neg_next    = (green < blue);
      n_next      = neg_next ? blue - green : green - blue;
    end else if (green >= mx_next) begin
      sector_next = SEC_GREEN;
      neg_next    = (blue < red);
      n_next      = neg_next ? red - blue : blue - red;
    end else begin
      sector_next = SEC_BLUE;
      neg_next    = (red < green);
      n_next      = neg_next ? green - red : red - green;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_grey   <= (mx_next == mn_next);
      a_neg    <= neg_next;
      a_sector <= sector_next;
      a_mx     <= mx_next;
      a_delta  <= mx_next - mn_next;
      a_n      <= n_next;
    end
  end

  // stage B: numerators; a negative offset is ceiled by adding delta - 1
  logic [NUM_W-1:0] sat_num;
  logic [NUM_W-1:0] hue_num;
  logic [NUM_W-1:0] n_w;
  logic [NUM_W-1:0] delta_w;
  pix_t             b_next;
  logic             b_valid;
  pix_t             b_data;

  always_comb begin
    n_w     = NUM_W'(a_n);
    delta_w = NUM_W'(a_delta);
    sat_num = (delta_w << CH_W) - delta_w;
    hue_num = n_w * NUM_W'(HUE_SECTOR) + (a_neg ? delta_w - NUM_W'(1) : '0);

    b_next.grey    = a_grey;
    b_next.neg     = a_neg;
    b_next.sector  = a_sector;
    b_next.mx      = a_mx;
    b_next.delta   = a_delta;
    b_next.sat_rem = sat_num[NUM_W-1:QW];
    b_next.sat_lo  = sat_num[QW-1:0];
    b_next.hue_rem = hue_num[NUM_W-1:QW];
    b_next.hue_lo  = hue_num[QW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (advance) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_data <= b_next;
    end
  end

  // divider stages
  logic dv_valid [QW+1];
  pix_t dv_data  [QW+1];

  assign dv_valid[0] = b_valid;
  assign dv_data[0]  = b_data;

  for (genvar i = 0; i < QW; i++) begin : g_div
    rgbhsv_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .in_valid  (dv_valid[i]),
      .in_data   (dv_data[i]),
      .out_valid (dv_valid[i+1]),
      .out_data  (dv_data[i+1])
    );
  end

  // output stage: apply the sector offset
  pix_t             fin;
  logic [HUE_W-1:0] hue_q;
  logic [HUE_W-1:0] hue_base;
  logic [HUE_W-1:0] hue_next;

  always_comb begin
    fin   = dv_data[QW];
    hue_q = HUE_W'(fin.hue_lo[HQ_W-1:0]);
    case (fin.sector)
      SEC_RED:   hue_base = fin.neg ? HUE_FULL : '0;
      SEC_GREEN: hue_base = HUE_GREEN;
      SEC_BLUE:  hue_base = HUE_BLUE;
      default:   hue_base = '0;
    endcase
    if (fin.grey) begin
      hue_next = '0;
    end else if (fin.neg) begin
      hue_next = hue_base - hue_q;
    end else begin
      hue_next = hue_base + hue_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= dv_valid[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hue        <= hue_next;
      saturation <= fin.grey ? '0 : fin.sat_lo[CH_W-1:0];
      brightness <= fin.mx;
    end
  end

`ifndef NO_ASSERTIONS
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hue < HUE_FULL)
    else $error("hue out of range");

  a_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && brightness == '0 |-> saturation == '0 && hue == '0)
    else $error("black pixel with nonzero hue or saturation");

  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturation == '0 |-> hue == '0)
    else $error("zero saturation with nonzero hue");

  a_stall_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");
`endif

endmodule

`default_nettype wire
